/* hdl/tac_pkg.sv */
// Package for the tiny accumulator CPU core: opcode codes, ALU selects,
// the program store write request and the per-transaction result record.
// No dependencies.
package tac_pkg;

    localparam logic [3:0] OP_LDA = 4'h0;
    localparam logic [3:0] OP_LDB = 4'h1;
    localparam logic [3:0] OP_OUT = 4'h2;
    localparam logic [3:0] OP_JNC = 4'h7;
    localparam logic [3:0] OP_JMP = 4'hB;

    localparam logic [3:0] ALU_ADD = 4'h0;
    localparam logic [3:0] ALU_SUB = 4'h4;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;

    typedef struct packed {
        logic       en;
        logic [7:0] addr;
        logic [7:0] data;
    } store_wr_t;

    typedef struct packed {
        logic       halted;
        logic       unknown_op;
        logic       executed;
        logic       out_written;
        logic       carry;
        logic [7:0] reg_out;
        logic [7:0] reg_b;
        logic [7:0] reg_a;
        logic [7:0] pc;
    } result_t;

endpackage

/* hdl/tac_prog_store.sv */
// Program store for the tiny accumulator CPU core: one write and one
// registered read per cycle, per-entry valid bits so unwritten bytes read 0.
// Depends on tac_pkg.
module tac_prog_store #(
    parameter int DEPTH = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  tac_pkg::store_wr_t  wr,
    input  logic [7:0]          rd_addr,
    output logic [7:0]          rd_data
);
    import tac_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);

    logic [7:0]        mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [7:0]        mem_q_reg;
    logic              valid_q_reg;
    logic              byp_reg;
    logic [7:0]        byp_data_reg;

    logic              wr_ok;
    logic              byp_next;
    logic [ADDR_W-1:0] wa;
    logic [ADDR_W-1:0] ra;

    assign wr_ok    = wr.en && ({1'b0, wr.addr} < 9'(DEPTH));
    assign wa       = wr.addr[ADDR_W-1:0];
    assign ra       = rd_addr[ADDR_W-1:0];
    assign byp_next = wr_ok && (wr.addr == rd_addr);

    always_ff @(posedge aclk) begin
        if (wr_ok) begin
            mem[wa] <= wr.data;
        end
        mem_q_reg    <= mem[ra];
        byp_data_reg <= wr.data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            valid_q_reg <= 1'b0;
            byp_reg     <= 1'b0;
        end else begin
            if (wr_ok) begin
                valid_reg[wa] <= 1'b1;
            end
            valid_q_reg <= valid_reg[ra];
            byp_reg     <= byp_next;
        end
    end

    // write in the same cycle as the read wins
    assign rd_data = byp_reg ? byp_data_reg : (valid_q_reg ? mem_q_reg : 8'h00);

endmodule

/* hdl/tiny_accumulator_cpu_core_top.sv */
// Tiny accumulator CPU core, top level.
// Result path: an input transaction passes the input register, then the result register.
// Throughput: one transaction per cycle unless m_tready stalls the output; the program
// store read of the next pc is issued in the same cycle as the current instruction executes.
// Reset (aresetn low, synchronous): A, B and output registers, pc, flags and store valid bits clear at once.
// Depends on tac_pkg and tac_prog_store.
module tiny_accumulator_cpu_core_top #(
    parameter int MEM_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // load_addr[7:0], load_data[15:8]
    input  logic        s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // pc, reg_a, reg_b, reg_out, carry, out_written,
                                   // executed, unknown_op, halted, zero pad
);
    import tac_pkg::*;

    localparam logic [7:0] PC_LAST = 8'(MEM_DEPTH - 1);

    logic        in_valid_reg, in_valid_next;
    logic        in_mode_reg;
    logic [7:0]  in_addr_reg;
    logic [7:0]  in_data_reg;

    logic [7:0]  pc_reg, pc_next;
    logic [7:0]  a_reg, a_next;
    logic [7:0]  b_reg, b_next;
    logic [7:0]  outr_reg, outr_next;
    logic        carry_reg, carry_next;
    logic        halt_reg, halt_next;

    logic        out_valid_reg, out_valid_next;
    result_t     res_reg, res_next;

    logic        accept;
    logic        fire;
    store_wr_t   wr;
    logic [7:0]  fetched;
    logic [3:0]  op;
    logic [3:0]  low;
    logic [8:0]  sum;
    logic [7:0]  alu_val;
    logic        alu_c;
    logic [7:0]  pc_inc;
    logic        jumped;
    logic        wrote;
    logic        exec;
    logic        unk;

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign accept   = s_tvalid && s_tready;

    tac_prog_store #(.DEPTH(MEM_DEPTH)) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (wr),
        .rd_addr (pc_next),
        .rd_data (fetched)
    );

    assign op     = fetched[7:4];
    assign low    = fetched[3:0];
    assign sum    = {1'b0, a_reg} + {1'b0, b_reg};
    assign pc_inc = (pc_reg == PC_LAST) ? 8'h00 : pc_reg + 8'h01;

    always_comb begin
        case (low)
            ALU_ADD: begin
                alu_val = sum[7:0];
                alu_c   = sum[8];
            end
            ALU_SUB: begin
                alu_val = a_reg - b_reg;
                alu_c   = a_reg < b_reg;
            end
            default: begin
                alu_val = {4'h0, low};
                alu_c   = carry_reg;
            end
        endcase
    end

    always_comb begin
        pc_next    = pc_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        outr_next  = outr_reg;
        carry_next = carry_reg;
        halt_next  = halt_reg;
        wr         = '0;
        jumped     = 1'b0;
        wrote      = 1'b0;
        exec       = 1'b0;
        unk        = 1'b0;
        if (fire) begin
            if (in_mode_reg == MODE_LOAD) begin
                wr.en   = 1'b1;
                wr.addr = in_addr_reg;
                wr.data = in_data_reg;
            end else if (!halt_reg) begin
                pc_next = pc_inc;
                if (fetched != 8'h00) begin
                    exec = 1'b1;
                    case (op)
                        OP_LDA: begin
                            a_next     = alu_val;
                            carry_next = alu_c;
                        end
                        OP_LDB: begin
                            b_next     = alu_val;
                            carry_next = alu_c;
                        end
                        OP_OUT: begin
                            outr_next = a_reg;
                            wrote     = 1'b1;
                        end
                        OP_JNC: begin
                            if (!carry_reg) begin
                                pc_next = {4'h0, low};
                                jumped  = 1'b1;
                            end
                        end
                        OP_JMP: begin
                            pc_next = {4'h0, low};
                            jumped  = 1'b1;
                        end
                        default: begin
                            unk = 1'b1;
                        end
                    endcase
                end
                if ((pc_reg == PC_LAST) && !jumped) begin
                    halt_next = 1'b1;
                end
            end
        end
    end

    always_comb begin
        res_next.pc          = pc_next;
        res_next.reg_a       = a_next;
        res_next.reg_b       = b_next;
        res_next.reg_out     = outr_next;
        res_next.carry       = carry_next;
        res_next.out_written = wrote;
        res_next.executed    = exec;
        res_next.unknown_op  = unk;
        res_next.halted      = halt_next;
    end

    assign in_valid_next  = accept ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
    assign out_valid_next = fire ? 1'b1 : ((out_valid_reg && m_tready) ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pc_reg        <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            outr_reg      <= '0;
            carry_reg     <= 1'b0;
            halt_reg      <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            pc_reg        <= pc_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            outr_reg      <= outr_next;
            carry_reg     <= carry_next;
            halt_reg      <= halt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_mode_reg <= s_tuser;
            in_addr_reg <= s_tdata[7:0];
            in_data_reg <= s_tdata[15:8];
        end
        if (fire) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, res_reg};

    assert property (@(posedge aclk) disable iff (!aresetn) halt_reg |=> halt_reg)
        else $error("halt flag cleared without reset");

    assert property (@(posedge aclk) disable iff (!aresetn) pc_reg <= PC_LAST)
        else $error("pc outside program store");

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && res_reg.out_written |-> res_reg.reg_out == res_reg.reg_a)
        else $error("output register does not match A after copy");

    assert property (@(posedge aclk) disable iff (!aresetn)
        fire && halt_reg && (in_mode_reg == MODE_STEP) |=> $stable(pc_reg))
        else $error("pc moved while halted");

endmodule
